FILE: src/utf8af_pkg.sv
package utf8af_pkg;

  localparam logic [7:0] LEAD_LATIN1 = 8'hC3;
  localparam logic [7:0] LEAD_PUNCT  = 8'hE2;
  localparam logic [7:0] NUL_BYTE    = 8'h00;
  localparam logic [7:0] DQUOTE      = 8'h22;
  localparam logic [7:0] PERIOD      = 8'h2E;
  localparam logic [7:0] SQUOTE      = 8'h27;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] folded_char;
    logic       end_of_text;
  } out_t;

  typedef struct packed {
    logic [2:0] bytes_left;
    logic [7:0] lead_byte;
    logic [2:0] byte_position;
    logic [7:0] pending_char;
  } seq_state_t;

  function automatic logic [3:0] leading_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      run = run & b[i];
      n   = n + {3'd0, run};
    end
    return n;
  endfunction

  function automatic logic [7:0] fold_latin1(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      8'h80, 8'h81, 8'h82, 8'h83:  c = "A";
      8'h88, 8'h89, 8'h8A:         c = "E";
      8'h8C, 8'h8D:                c = "I";
      8'h92, 8'h93, 8'h94, 8'h95:  c = "O";
      8'h99, 8'h9A:                c = "U";
      8'h87:                       c = "C";
      8'hA0, 8'hA1, 8'hA2, 8'hA3:  c = "a";
      8'hA8, 8'hA9, 8'hAA:         c = "e";
      8'hAC, 8'hAD:                c = "i";
      8'hB2, 8'hB3, 8'hB4, 8'hB5:  c = "o";
      8'hB9, 8'hBA:                c = "u";
      8'hA7:                       c = "c";
      default:                     c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] fold_punct(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      8'h9C, 8'h9D: c = DQUOTE;
      8'h93, 8'hA6: c = PERIOD;
      8'h98, 8'h99: c = SQUOTE;
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: src/utf8af_step.sv
module utf8af_step (
  input  utf8af_pkg::in_t        word,
  input  utf8af_pkg::seq_state_t cur,
  output utf8af_pkg::seq_state_t nxt,
  output logic                   emit,
  output utf8af_pkg::out_t       result
);
  import utf8af_pkg::*;

  logic [3:0] n_ones;
  logic [7:0] pend;
  logic [2:0] left_dec;

  function automatic logic [2:0] left_dec_of(input logic [3:0] n);
    logic [3:0] d;
    d = n - 4'd1;
    return d[2:0];
  endfunction

  assign n_ones   = leading_ones(word.data_byte);
  assign left_dec = cur.bytes_left - 3'd1;

  always_comb begin
    if (cur.lead_byte == LEAD_LATIN1 && cur.byte_position == 3'd1) begin
      pend = fold_latin1(word.data_byte);
    end else if (cur.lead_byte == LEAD_PUNCT && cur.byte_position == 3'd2) begin
      pend = fold_punct(word.data_byte);
    end else begin
      pend = cur.pending_char;
    end
  end

  always_comb begin
    nxt    = '0;
    emit   = 1'b0;
    result = '0;
    if (cur.bytes_left == 3'd0) begin
      if (word.data_byte == NUL_BYTE) begin
        emit               = 1'b1;
        result.end_of_text = 1'b1;
      end else if (n_ones < 4'd2) begin
        emit               = 1'b1;
        result.folded_char = word.data_byte;
        result.end_of_text = word.last_byte;
      end else if (word.last_byte) begin
        emit               = 1'b1;
        result.end_of_text = 1'b1;
      end else begin
        nxt.bytes_left    = left_dec_of(n_ones);
        nxt.lead_byte     = word.data_byte;
        nxt.byte_position = 3'd1;
        nxt.pending_char  = (word.data_byte == LEAD_LATIN1 ||
                             word.data_byte == LEAD_PUNCT) ? 8'h00 : word.data_byte;
      end
    end else begin
      if (left_dec == 3'd0) begin
        emit               = 1'b1;
        result.folded_char = pend;
        result.end_of_text = word.last_byte;
      end else if (word.last_byte) begin
        emit               = 1'b1;
        result.end_of_text = 1'b1;
      end else begin
        nxt.bytes_left    = left_dec;
        nxt.lead_byte     = cur.lead_byte;
        nxt.byte_position = cur.byte_position + 3'd1;
        nxt.pending_char  = pend;
      end
    end
  end

endmodule

FILE: src/utf8_accent_folding_decoder.sv
// A word accepted into the hold register is decoded there; its result is registered in the output register.
// Throughput: one byte per cycle while results are taken; a byte that yields no
// character moves on while a result waits, and a second result stalls the input.
// Reset (rst_n low, synchronous) empties both registers and closes any open
// sequence, so the next byte is decoded as a fresh lead.
module utf8_accent_folding_decoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  utf8af_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output utf8af_pkg::out_t out_data
);
  import utf8af_pkg::*;

  logic       hold_valid_r;
  in_t        hold_word_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  logic       out_valid_r;
  out_t       out_word_r;
  logic       emit;
  out_t       result;
  logic       advance;

  utf8af_step u_step (
    .word   (hold_word_r),
    .cur    (state_r),
    .nxt    (state_nxt),
    .emit   (emit),
    .result (result)
  );

  assign advance   = hold_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready  = !hold_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= '0;
    end else begin
      if (in_ready) begin
        hold_valid_r <= in_valid;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_word_r <= in_data;
    end
    if (advance && emit) begin
      out_word_r <= result;
    end
  end

endmodule

FILE: src/utf8af_checker.sv
module utf8af_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input utf8af_pkg::in_t  in_data,
  input logic             out_valid,
  input logic             out_ready,
  input utf8af_pkg::out_t out_data
);
  import utf8af_pkg::*;

  // Reset must empty the output register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word present after reset");

  // With the output register empty, the input side is never held off.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word changed or dropped while stalled");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output word changed while stalled");

endmodule

bind utf8_accent_folding_decoder utf8af_checker u_utf8af_checker (.*);
